/* rtl/frsd_pkg.sv */
// Package for the flow rate stability detector.
// Holds sizes, constants, register indexes and the types shared by the RTL files.
// No dependencies.
`default_nettype none
package frsd_pkg;

    // Depth of the sliding window store.
    localparam int MAX_WINDOWS = 16;
    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = 5;
    localparam int SUM_W = 32 + CNT_W;

    // Shared divider: widest dividend is pulses * 100000 plus a rounding term.
    localparam int DIV_W = 49;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Arithmetic constants.
    localparam logic [31:0] MS_PER_SEC = 32'd1000;
    localparam logic [16:0] RATE_SCALE = 17'd100000;
    localparam logic [31:0] PCT_DIV = 32'd100;
    localparam logic [13:0] PCT_ROUND = 14'd50;

    // Division by 100 of any 32-bit value: multiply by this and drop PCT_SHIFT bits.
    localparam logic [31:0] PCT_RECIP = 32'h51EB_851F;
    localparam int PCT_SHIFT = 37;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SEC = 2'd0;
    localparam logic [1:0] CFG_VAR_PCT = 2'd1;
    localparam logic [1:0] CFG_REQ_WIN = 2'd2;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_OBSERVE = 1'b1;

    // One store entry: window rate and the window origin.
    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] origin_ms;
        logic [31:0] origin_pulses;
    } entry_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/flow_rate_stability_detector_core.sv */
// Top level of the flow rate stability detector; uses frsd_pkg and frsd_div.
// A start word or a word that closes no window goes from idle to the output state, then the output reg.
// A closing word runs a divider pass for the rate; before a steady run it then writes or slides
// the window into the store, scans a full store, and takes up to two more passes (average, tolerance).
// Throughput: one word in work at a time, the next taken once the result is in the output reg.
// Reset (rst_n, asynchronous) clears flags, counters and held rates; registers take defaults.
`default_nettype none
module flow_rate_stability_detector_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] pulse_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             window_closed,
    output logic [31:0]      latest_rate,
    output logic             steady_found,
    output logic             unstable_after_steady,
    output logic [31:0]      steady_origin_ms,
    output logic [31:0]      steady_origin_pulses,
    output logic [31:0]      steady_average_rate,
    output logic [4:0]       windows_collected
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_RDIV  = 4'd2;
    localparam logic [3:0] ST_SHRD  = 4'd3;
    localparam logic [3:0] ST_SHWR  = 4'd4;
    localparam logic [3:0] ST_PUSH  = 4'd5;
    localparam logic [3:0] ST_CKBEG = 4'd6;
    localparam logic [3:0] ST_CKRD  = 4'd7;
    localparam logic [3:0] ST_CKACC = 4'd8;
    localparam logic [3:0] ST_AVGS  = 4'd9;
    localparam logic [3:0] ST_AVGW  = 4'd10;
    localparam logic [3:0] ST_TMUL  = 4'd11;
    localparam logic [3:0] ST_TDIV1 = 4'd12;
    localparam logic [3:0] ST_TDIV2 = 4'd13;
    localparam logic [3:0] ST_TCMP  = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [7:0] window_sec_reg;
    logic [6:0] var_pct_reg;
    logic [4:0] req_win_reg;

    // Detector state.
    logic [31:0]                open_ms_reg;
    logic [31:0]                open_pl_reg;
    logic [frsd_pkg::CNT_W-1:0] count_reg;
    logic                       steady_reg;
    logic                       unstable_reg;
    logic [31:0]                steady_ms_reg;
    logic [31:0]                steady_pl_reg;
    logic [31:0]                average_reg;
    logic [31:0]                last_rate_reg;
    logic                       closed_reg;
    logic                       out_valid_reg;

    // Working registers of one word.
    logic [31:0]                now_reg;
    logic [31:0]                cnt_reg;
    logic [31:0]                oms_reg;
    logic [31:0]                opl_reg;
    logic [31:0]                elapsed_reg;
    logic [31:0]                pulses_reg;
    logic [31:0]                rate_reg;
    logic [frsd_pkg::CNT_W-1:0] idx_reg;
    logic [frsd_pkg::SUM_W-1:0] sum_reg;
    logic [31:0]                lo_reg;
    logic [31:0]                hi_reg;
    logic                       zero_reg;
    logic [31:0]                org_ms_reg;
    logic [31:0]                org_pl_reg;
    logic [31:0]                avg_cand_reg;
    logic [31:0]                tol_arg_reg;
    logic [31:0]                pct_tol_reg;
    logic [31:0]                tol_reg;
    logic                       tol_check_reg;

    // Percent tolerance pipeline: quotient and remainder of the argument by 100.
    logic [25:0]                pq_reg;
    logic [6:0]                 prem_reg;
    logic [13:0]                py_reg;
    logic [6:0]                 pyq_reg;
    logic [63:0]                pq_prod;
    logic [31:0]                prem_full;
    logic [13:0]                py_sum;
    logic [45:0]                py_prod;

    // Held result word.
    logic        o_closed_reg;
    logic [31:0] o_rate_reg;
    logic        o_steady_reg;
    logic        o_unstable_reg;
    logic [31:0] o_ms_reg;
    logic [31:0] o_pl_reg;
    logic [31:0] o_avg_reg;
    logic [4:0]  o_count_reg;

    // Window store memory.
    frsd_pkg::entry_t           store_mem [frsd_pkg::MAX_WINDOWS];
    frsd_pkg::entry_t           mem_q;
    logic                       mem_we;
    logic                       mem_re;
    logic [frsd_pkg::IDX_W-1:0] mem_waddr;
    logic [frsd_pkg::IDX_W-1:0] mem_raddr;
    frsd_pkg::entry_t           mem_wdata;

    frsd_pkg::div_req_t div_req;
    frsd_pkg::div_rsp_t div_rsp;

    logic [7:0]                 eff_ws;
    logic [frsd_pkg::CNT_W-1:0] lim;
    logic [31:0]                elapsed;
    logic [31:0]                need;
    logic                       closes;
    logic                       in_fire;
    logic                       out_load;
    logic [31:0]                rate_sat;
    logic [31:0]                dev;
    logic [31:0]                one_tol;

    // Effective register values.
    assign eff_ws = (window_sec_reg == 8'd0) ? 8'd1 : window_sec_reg;
    always_comb
    begin
        priority if (req_win_reg == 5'd0)
        begin
            lim = frsd_pkg::CNT_W'(1);
        end
        else if (32'(req_win_reg) > 32'(frsd_pkg::MAX_WINDOWS))
        begin
            lim = frsd_pkg::CNT_W'(frsd_pkg::MAX_WINDOWS);
        end
        else
        begin
            lim = frsd_pkg::CNT_W'(req_win_reg);
        end
    end

    assign elapsed = now_ms - open_ms_reg;
    assign need = 32'(eff_ws) * frsd_pkg::MS_PER_SEC;
    assign closes = (elapsed >= need) && (elapsed != 32'd0);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign rate_sat = (div_rsp.quotient > frsd_pkg::DIV_W'(32'hFFFF_FFFF)) ?
                      32'hFFFF_FFFF : div_rsp.quotient[31:0];
    assign dev = (rate_reg > average_reg) ? (rate_reg - average_reg) :
                 (average_reg - rate_reg);
    assign one_tol = div_rsp.quotient[31:0];

    // Rounded percent of the argument, split as arg = 100 * q + r, one step per cycle.
    assign pq_prod = 64'(tol_arg_reg) * 64'(frsd_pkg::PCT_RECIP);
    assign prem_full = tol_arg_reg - 32'(pq_reg) * frsd_pkg::PCT_DIV;
    assign py_sum = 14'(prem_reg) * 14'(var_pct_reg) + frsd_pkg::PCT_ROUND;
    assign py_prod = 46'(py_reg) * 46'(frsd_pkg::PCT_RECIP);

    // Sequencer, memory port and divider requests.
    always_comb
    begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = idx_reg[frsd_pkg::IDX_W-1:0];
        mem_raddr = idx_reg[frsd_pkg::IDX_W-1:0];
        mem_wdata = mem_q;
        div_req.start = 1'b0;
        div_req.dividend = '0;
        div_req.divisor = 32'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (operation == frsd_pkg::OP_OBSERVE && closes) ?
                                 ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                div_req.start = 1'b1;
                div_req.dividend = frsd_pkg::DIV_W'(pulses_reg)
                                   * frsd_pkg::DIV_W'(frsd_pkg::RATE_SCALE)
                                   + frsd_pkg::DIV_W'(elapsed_reg >> 1);
                div_req.divisor = elapsed_reg;
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (div_rsp.done)
                begin
                    priority if (steady_reg)
                    begin
                        state_next = ST_TMUL;
                    end
                    else if (count_reg < lim)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = count_reg[frsd_pkg::IDX_W-1:0];
                        mem_wdata = '{rate: rate_sat, origin_ms: oms_reg,
                                      origin_pulses: opl_reg};
                        state_next = ST_CKBEG;
                    end
                    else
                    begin
                        state_next = ST_SHRD;
                    end
                end
            end
            ST_SHRD:
            begin
                if (idx_reg < lim)
                begin
                    mem_re = 1'b1;
                    state_next = ST_SHWR;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_SHWR:
            begin
                mem_we = 1'b1;
                mem_waddr = frsd_pkg::IDX_W'(idx_reg - 1'b1);
                mem_wdata = mem_q;
                state_next = ST_SHRD;
            end
            ST_PUSH:
            begin
                mem_we = 1'b1;
                mem_waddr = frsd_pkg::IDX_W'(lim - 1'b1);
                mem_wdata = '{rate: rate_reg, origin_ms: oms_reg, origin_pulses: opl_reg};
                state_next = ST_CKBEG;
            end
            ST_CKBEG:
            begin
                state_next = (count_reg < lim) ? ST_OUT : ST_CKRD;
            end
            ST_CKRD:
            begin
                mem_re = 1'b1;
                state_next = ST_CKACC;
            end
            ST_CKACC:
            begin
                state_next = ((idx_reg + 1'b1) < lim) ? ST_CKRD : ST_AVGS;
            end
            ST_AVGS:
            begin
                if (zero_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = frsd_pkg::DIV_W'(sum_reg)
                                       + frsd_pkg::DIV_W'(lim >> 1);
                    div_req.divisor = 32'(lim);
                    state_next = ST_AVGW;
                end
            end
            ST_AVGW:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL:
            begin
                // One-pulse tolerance on the divider while the percent part is worked out.
                div_req.start = 1'b1;
                div_req.dividend = frsd_pkg::DIV_W'(32'd100 + 32'(eff_ws) - 32'd1);
                div_req.divisor = 32'(eff_ws);
                state_next = ST_TDIV1;
            end
            ST_TDIV1:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TDIV2;
                end
            end
            ST_TDIV2:
            begin
                state_next = ST_TCMP;
            end
            ST_TCMP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= store_mem[mem_raddr];
        end
    end

    // Configuration, control and detector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_sec_reg <= 8'd10;
            var_pct_reg    <= 7'd5;
            req_win_reg    <= 5'd3;
            open_ms_reg    <= '0;
            open_pl_reg    <= '0;
            count_reg      <= '0;
            steady_reg     <= 1'b0;
            unstable_reg   <= 1'b0;
            steady_ms_reg  <= '0;
            steady_pl_reg  <= '0;
            average_reg    <= '0;
            last_rate_reg  <= '0;
            closed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    frsd_pkg::CFG_WINDOW_SEC: window_sec_reg <= cfg_data;
                    frsd_pkg::CFG_VAR_PCT:    var_pct_reg <= cfg_data[6:0];
                    frsd_pkg::CFG_REQ_WIN:    req_win_reg <= cfg_data[4:0];
                    default:                  ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        closed_reg <= 1'b0;
                        if (operation == frsd_pkg::OP_START)
                        begin
                            open_ms_reg   <= now_ms;
                            open_pl_reg   <= pulse_count;
                            count_reg     <= '0;
                            steady_reg    <= 1'b0;
                            unstable_reg  <= 1'b0;
                            steady_ms_reg <= '0;
                            steady_pl_reg <= '0;
                            average_reg   <= '0;
                            last_rate_reg <= '0;
                        end
                    end
                end
                ST_RDIV:
                begin
                    if (div_rsp.done)
                    begin
                        closed_reg    <= 1'b1;
                        open_ms_reg   <= now_reg;
                        open_pl_reg   <= cnt_reg;
                        last_rate_reg <= rate_sat;
                        if (!steady_reg && count_reg < lim)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_TCMP:
                begin
                    if (!tol_check_reg)
                    begin
                        if (rate_reg == 32'd0 || dev > tol_reg)
                        begin
                            unstable_reg <= 1'b1;
                        end
                    end
                    else if ((hi_reg - lo_reg) <= tol_reg)
                    begin
                        steady_reg    <= 1'b1;
                        steady_ms_reg <= org_ms_reg;
                        steady_pl_reg <= org_pl_reg;
                        average_reg   <= avg_cand_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working datapath of the word in progress.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    now_reg     <= now_ms;
                    cnt_reg     <= pulse_count;
                    oms_reg     <= open_ms_reg;
                    opl_reg     <= open_pl_reg;
                    elapsed_reg <= elapsed;
                    pulses_reg  <= pulse_count - open_pl_reg;
                end
            end
            ST_RDIV:
            begin
                if (div_rsp.done)
                begin
                    rate_reg      <= rate_sat;
                    idx_reg       <= frsd_pkg::CNT_W'(1);
                    tol_arg_reg   <= average_reg;
                    tol_check_reg <= 1'b0;
                end
            end
            ST_SHWR:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            ST_CKBEG:
            begin
                idx_reg  <= '0;
                sum_reg  <= '0;
                lo_reg   <= 32'hFFFF_FFFF;
                hi_reg   <= '0;
                zero_reg <= 1'b0;
            end
            ST_CKACC:
            begin
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_reg + frsd_pkg::SUM_W'(mem_q.rate);
                if (mem_q.rate < lo_reg)
                begin
                    lo_reg <= mem_q.rate;
                end
                if (mem_q.rate > hi_reg)
                begin
                    hi_reg <= mem_q.rate;
                end
                if (mem_q.rate == 32'd0)
                begin
                    zero_reg <= 1'b1;
                end
                if (idx_reg == '0)
                begin
                    org_ms_reg <= mem_q.origin_ms;
                    org_pl_reg <= mem_q.origin_pulses;
                end
            end
            ST_AVGW:
            begin
                if (div_rsp.done)
                begin
                    avg_cand_reg  <= div_rsp.quotient[31:0];
                    tol_arg_reg   <= div_rsp.quotient[31:0];
                    tol_check_reg <= 1'b1;
                end
            end
            ST_TMUL:
            begin
                pq_reg <= pq_prod[frsd_pkg::PCT_SHIFT+25:frsd_pkg::PCT_SHIFT];
            end
            ST_TDIV1:
            begin
                // The percent pipeline settles well before the divider finishes its pass.
                prem_reg    <= prem_full[6:0];
                py_reg      <= py_sum;
                pyq_reg     <= py_prod[frsd_pkg::PCT_SHIFT+6:frsd_pkg::PCT_SHIFT];
                pct_tol_reg <= 32'(pq_reg) * 32'(var_pct_reg) + 32'(pyq_reg);
            end
            ST_TDIV2:
            begin
                tol_reg <= (pct_tol_reg > one_tol) ? pct_tol_reg : one_tol;
            end
            default:
            begin
            end
        endcase
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_closed_reg   <= closed_reg;
            o_rate_reg     <= last_rate_reg;
            o_steady_reg   <= steady_reg;
            o_unstable_reg <= unstable_reg;
            o_ms_reg       <= steady_ms_reg;
            o_pl_reg       <= steady_pl_reg;
            o_avg_reg      <= average_reg;
            o_count_reg    <= 5'(count_reg);
        end
    end

    frsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign window_closed = o_closed_reg;
    assign latest_rate = o_rate_reg;
    assign steady_found = o_steady_reg;
    assign unstable_after_steady = o_unstable_reg;
    assign steady_origin_ms = o_ms_reg;
    assign steady_origin_pulses = o_pl_reg;
    assign steady_average_rate = o_avg_reg;
    assign windows_collected = o_count_reg;

endmodule
`default_nettype wire

/* rtl/frsd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on frsd_pkg for widths and the request and response types.
`default_nettype none
module frsd_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire frsd_pkg::div_req_t req,
    output frsd_pkg::div_rsp_t      rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [frsd_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [frsd_pkg::DIV_W-1:0]      dvd_reg;
    logic [31:0]                     dvs_reg;
    logic [31:0]                     rem_reg;
    logic [32:0]                     rem_shift;
    logic                            fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign rem_shift = {rem_reg, dvd_reg[frsd_pkg::DIV_W-1]};
    assign fits = (rem_shift >= {1'b0, dvs_reg});

    // Control: bit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= frsd_pkg::DIV_CNT_W'(frsd_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == frsd_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: the dividend register shifts out and collects quotient bits.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[frsd_pkg::DIV_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= 32'(rem_shift - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule
`default_nettype wire

/* rtl/frsd_checker.sv */
// Port-level checks for the flow rate stability detector, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module frsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] latest_rate,
    input wire logic        steady_found,
    input wire logic        unstable_after_steady,
    input wire logic [4:0]  windows_collected
);

    // One word in work at a time: an accepted word closes the input side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in work");

    // A waiting result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latest_rate))
        else $error("result word changed while stalled");

    // Instability is only reported after a steady run.
    a_unstable_needs_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unstable_after_steady |-> steady_found)
        else $error("unstable flag without steady flag");

    // The store never reports more windows than it holds.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> windows_collected <= 5'd16)
        else $error("window count beyond store depth");

endmodule

bind flow_rate_stability_detector_core frsd_checker u_frsd_checker (.*);
`default_nettype wire

/* verif/flow_rate_stability_detector_checker.sv */
// Checker for the flow rate stability detector: watches both channels and the register port.
// Predicts each result word from its own copy of the detector state and compares field by field.
// Depends on frsd_pkg.
`timescale 1ns / 100ps
module flow_rate_stability_detector_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        operation,
    input  logic [31:0] now_ms,
    input  logic [31:0] pulse_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        window_closed,
    input  logic [31:0] latest_rate,
    input  logic        steady_found,
    input  logic        unstable_after_steady,
    input  logic [31:0] steady_origin_ms,
    input  logic [31:0] steady_origin_pulses,
    input  logic [31:0] steady_average_rate,
    input  logic [4:0]  windows_collected,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        closed;
        logic [31:0] rate;
        logic        steady;
        logic        unstable;
        logic [31:0] org_ms;
        logic [31:0] org_pulses;
        logic [31:0] avg;
        logic [4:0]  count;
    } status_t;

    status_t status_q[$];

    // Shadow registers and detector state.
    logic [7:0]  win_sec_cfg;
    logic [6:0]  pct_cfg;
    logic [4:0]  req_cfg;
    logic [31:0] open_ms, open_pulses;
    logic [31:0] rates[frsd_pkg::MAX_WINDOWS];
    logic [31:0] org_ms_mem[frsd_pkg::MAX_WINDOWS];
    logic [31:0] org_pl_mem[frsd_pkg::MAX_WINDOWS];
    int unsigned held;
    logic        steady, unstable;
    logic [31:0] st_ms, st_pulses, st_avg, last_rate;

    function automatic int unsigned win_len();
        return (win_sec_cfg == 0) ? 1 : win_sec_cfg;
    endfunction

    function automatic int unsigned run_len();
        if (req_cfg == 0) return 1;
        if (req_cfg > frsd_pkg::MAX_WINDOWS) return frsd_pkg::MAX_WINDOWS;
        return req_cfg;
    endfunction

    function automatic logic [31:0] spread_limit(logic [31:0] avg);
        logic [63:0] pct;
        logic [31:0] one;
        pct = (64'(avg) * pct_cfg + 64'd50) / 64'd100;
        one = (32'd100 + win_len() - 1) / win_len();
        return (pct[31:0] > one) ? pct[31:0] : one;
    endfunction

    // Slides the new window into the store and tries to latch a steady run.
    task automatic store_window(logic [31:0] oms, logic [31:0] opl, logic [31:0] rate);
        int unsigned lim;
        logic [31:0] lo, hi, avg;
        logic [63:0] sum;
        lim = run_len();
        if (held < lim) begin
            rates[held] = rate;
            org_ms_mem[held] = oms;
            org_pl_mem[held] = opl;
            held++;
        end
        else begin
            for (int i = 1; i < lim; i++) begin
                rates[i-1] = rates[i];
                org_ms_mem[i-1] = org_ms_mem[i];
                org_pl_mem[i-1] = org_pl_mem[i];
            end
            rates[lim-1] = rate;
            org_ms_mem[lim-1] = oms;
            org_pl_mem[lim-1] = opl;
        end
        if (held < lim) return;
        lo = '1;
        hi = 0;
        sum = 0;
        for (int i = 0; i < lim; i++) begin
            if (rates[i] == 0) return;
            if (rates[i] < lo) lo = rates[i];
            if (rates[i] > hi) hi = rates[i];
            sum += rates[i];
        end
        avg = 32'((sum + lim / 2) / lim);
        if (hi - lo > spread_limit(avg)) return;
        steady = 1'b1;
        st_ms = org_ms_mem[0];
        st_pulses = org_pl_mem[0];
        st_avg = avg;
    endtask

    // Applies one accepted word and returns the expected status.
    task automatic detect_step(logic op, logic [31:0] now, logic [31:0] cnt, output status_t s);
        logic [31:0] elapsed, pulses, rate, dev, oms, opl;
        logic [63:0] q;
        s.closed = 1'b0;
        if (op == frsd_pkg::OP_START) begin
            open_ms = now;
            open_pulses = cnt;
            held = 0;
            steady = 0;
            unstable = 0;
            st_ms = 0;
            st_pulses = 0;
            st_avg = 0;
            last_rate = 0;
        end
        else begin
            elapsed = now - open_ms;
            if (elapsed >= win_len() * 1000 && elapsed != 0) begin
                pulses = cnt - open_pulses;
                q = (64'(pulses) * 64'd100000 + 64'(elapsed / 2)) / 64'(elapsed);
                rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                oms = open_ms;
                opl = open_pulses;
                s.closed = 1'b1;
                open_ms = now;
                open_pulses = cnt;
                last_rate = rate;
                if (steady) begin
                    dev = (rate > st_avg) ? rate - st_avg : st_avg - rate;
                    if (rate == 0 || dev > spread_limit(st_avg)) unstable = 1'b1;
                end
                else begin
                    store_window(oms, opl, rate);
                end
            end
        end
        s.rate = last_rate;
        s.steady = steady;
        s.unstable = unstable;
        s.org_ms = st_ms;
        s.org_pulses = st_pulses;
        s.avg = st_avg;
        s.count = 5'(held);
    endtask

    assign pending_count = status_q.size();

    always @(posedge clk or negedge rst_n) begin
        status_t exp_s, got_s;
        if (!rst_n) begin
            win_sec_cfg <= 8'd10;
            pct_cfg <= 7'd5;
            req_cfg <= 5'd3;
            open_ms = 0;
            open_pulses = 0;
            held = 0;
            steady = 0;
            unstable = 0;
            st_ms = 0;
            st_pulses = 0;
            st_avg = 0;
            last_rate = 0;
            fail_count <= 0;
            status_q.delete();
        end
        else begin
            // Register writes.
            if (cfg_we) begin
                case (cfg_index)
                    frsd_pkg::CFG_WINDOW_SEC: win_sec_cfg <= cfg_data;
                    frsd_pkg::CFG_VAR_PCT:    pct_cfg <= cfg_data[6:0];
                    frsd_pkg::CFG_REQ_WIN:    req_cfg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            // Accepted input word.
            if (in_valid && in_ready) begin
                detect_step(operation, now_ms, pulse_count, exp_s);
                status_q.push_back(exp_s);
            end
            // Accepted result word.
            if (out_valid && out_ready) begin
                got_s = {window_closed, latest_rate, steady_found, unstable_after_steady,
                         steady_origin_ms, steady_origin_pulses, steady_average_rate,
                         windows_collected};
                if (status_q.size() == 0) begin
                    if (fail_count < 10) $display("Result word with nothing expected: %h", got_s);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_s = status_q.pop_front();
                    if (exp_s !== got_s) begin
                        if (fail_count < 10) begin
                            $display("Mismatch: closed %b/%b rate %h/%h steady %b/%b unst %b/%b",
                                     exp_s.closed, got_s.closed, exp_s.rate, got_s.rate,
                                     exp_s.steady, got_s.steady, exp_s.unstable, got_s.unstable);
                            $display("  origin %h/%h pulses %h/%h avg %h/%h count %0d/%0d",
                                     exp_s.org_ms, got_s.org_ms, exp_s.org_pulses,
                                     got_s.org_pulses, exp_s.avg, got_s.avg,
                                     exp_s.count, got_s.count);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* verif/flow_rate_stability_detector_core_tb.sv */
// Testbench top for the flow rate stability detector: clock, reset, stimulus and verdict.
// Depends on frsd_pkg, flow_rate_stability_detector_core and the checker module.
`timescale 1ns / 100ps
module flow_rate_stability_detector_core_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid, in_ready;
    logic        operation;
    logic [31:0] now_ms, pulse_count;
    logic        out_valid, out_ready;
    logic        window_closed, steady_found, unstable_after_steady;
    logic [31:0] latest_rate, steady_origin_ms, steady_origin_pulses, steady_average_rate;
    logic [4:0]  windows_collected;
    int          fail_count, pending_count;

    int          send_idle_pct, recv_idle_pct;
    logic        hold_off;
    longint      cycle_count;
    logic [31:0] t_now, p_now;

    flow_rate_stability_detector_core u_dut (.*);

    flow_rate_stability_detector_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout guard.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3_000_000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one word and waits until it is accepted; valid stays up for a following word.
    task automatic send_word(logic op, logic [31:0] t, logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        now_ms <= t;
        pulse_count <= p;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drives one register write; the caller drops the write enable after its last write.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Waits until every result is back and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // A run of windows with a base rate and some jitter, mostly well formed.
    task automatic flow_run(int n, int unsigned wsec);
        int unsigned base, step;
        t_now = $urandom;
        p_now = $urandom;
        send_word(frsd_pkg::OP_START, t_now, p_now);
        base = $urandom_range(1, 3) == 1 ? $urandom_range(0, 20) : $urandom_range(50, 5000);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: step = $urandom_range(1, wsec * 1000);
                1: step = $urandom;
                default: step = wsec * 1000 + $urandom_range(0, 40);
            endcase
            t_now += step;
            if ($urandom_range(19) == 0) p_now += $urandom;
            else p_now += (base + $urandom_range(0, base / 16 + 1)) * step / 1000 / 10;
            send_word($urandom_range(40) == 0 ? frsd_pkg::OP_START : frsd_pkg::OP_OBSERVE,
                      t_now, p_now);
        end
    endtask

    task automatic random_config();
        int unsigned w;
        case ($urandom_range(3))
            0: w = 0;
            1: w = 255;
            default: w = $urandom_range(1, 5);
        endcase
        write_reg(frsd_pkg::CFG_WINDOW_SEC, 8'(w));
        write_reg(frsd_pkg::CFG_VAR_PCT, 8'($urandom_range(0, 127)));
        write_reg(frsd_pkg::CFG_REQ_WIN, 8'($urandom_range(0, 31)));
        cfg_we <= 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = frsd_pkg::OP_START;
        now_ms = '0;
        pulse_count = '0;
        hold_off = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 68;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: observe before any start, extremes of the fields.
        send_word(frsd_pkg::OP_OBSERVE, 32'd10000, 32'hFFFF_FFFF);
        send_word(frsd_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 32'h0);
        send_word(frsd_pkg::OP_START, 32'hFFFF_F000, 32'hFFFF_FF00);
        send_word(frsd_pkg::OP_OBSERVE, 32'd9000, 32'd100);
        send_word(frsd_pkg::OP_OBSERVE, 32'd19000, 32'd200);
        send_word(frsd_pkg::OP_OBSERVE, 32'd29000, 32'd300);
        send_word(frsd_pkg::OP_OBSERVE, 32'd39000, 32'd250);
        send_word(frsd_pkg::OP_OBSERVE, 32'd49000, 32'd250);
        drain();
        // Zero window length, wide percent, one required window, saturated rate.
        write_reg(frsd_pkg::CFG_WINDOW_SEC, 8'd0);
        write_reg(frsd_pkg::CFG_VAR_PCT, 8'd127);
        write_reg(frsd_pkg::CFG_REQ_WIN, 8'd0);
        cfg_we <= 1'b0;
        send_word(frsd_pkg::OP_START, 32'd0, 32'd0);
        send_word(frsd_pkg::OP_OBSERVE, 32'd1, 32'hFFFF_FFFF);
        send_word(frsd_pkg::OP_OBSERVE, 32'd1000, 32'h7FFF_FFFF);
        send_word(frsd_pkg::OP_OBSERVE, 32'd2000, 32'h7FFF_FFFF);
        drain();
        // Most windows required, then lowered while running.
        write_reg(frsd_pkg::CFG_WINDOW_SEC, 8'd1);
        write_reg(frsd_pkg::CFG_VAR_PCT, 8'd0);
        write_reg(frsd_pkg::CFG_REQ_WIN, 8'd31);
        cfg_we <= 1'b0;
        send_word(frsd_pkg::OP_START, 32'd0, 32'd0);
        for (int i = 1; i <= 6; i++)
            send_word(frsd_pkg::OP_OBSERVE, 32'(i * 1000), 32'(i * (i + 3)));
        drain();
        write_reg(frsd_pkg::CFG_REQ_WIN, 8'd2);
        cfg_we <= 1'b0;
        send_word(frsd_pkg::OP_OBSERVE, 32'd7000, 32'd60);
        send_word(frsd_pkg::OP_OBSERVE, 32'd8000, 32'd70);
        drain();

        // Random phases across the three idling patterns.
        for (int ph = 0; ph < 30; ph++) begin
            if (ph == 10) begin
                send_idle_pct = 68;
                recv_idle_pct = 34;
            end
            if (ph == 20) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            if (ph == 25) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (2000) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                    flow_run(37, (u_checker.win_sec_cfg == 0) ? 1 : u_checker.win_sec_cfg);
                join
            end
            else begin
                flow_run(37, (u_checker.win_sec_cfg == 0) ? 1 : u_checker.win_sec_cfg);
            end
            drain();
        end

        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
